[hw/rtl/pbt_pkg.sv]
// Shared types and constants of the periodic timer bank.
package pbt_pkg;

    localparam int REQ_W      = 3;
    localparam int IDX_W      = 2;
    localparam int PERIOD_W   = 16;
    localparam int MASK_W     = 4;
    localparam int OUT_TICK_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // timers that own a period register
    localparam int MAX_TIMERS = 4;

    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START_ONE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP_ONE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_START_ALL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STOP_ALL  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LAST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_WRITE
    } pbt_state_t;

    typedef struct packed {
        logic             tick_accept;
        logic             apply_req;
        logic             step;
        logic             timer_done;
        logic             load_out;
        logic [IDX_W-1:0] sel;
    } pbt_cmd_t;

    typedef struct packed {
        logic out_free;
    } pbt_sts_t;

endpackage

[hw/rtl/pbt_ctrl.sv]
// Sequencer: request intake, per-timer remainder steps, result hand-off.
module pbt_ctrl
    import pbt_pkg::*;
#(
    parameter int NT    = 4,
    parameter int STEPS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [REQ_W-1:0] req_type,
    output logic             req_stall,
    output pbt_cmd_t         cmd,
    input  pbt_sts_t         sts
);

    localparam int TW = (NT > 1) ? $clog2(NT) : 1;
    localparam int SW = $clog2(STEPS);

    pbt_state_t      state_reg, state_next;
    logic [TW-1:0]   tmr_reg, tmr_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            last_step;
    logic            last_tmr;
    logic            req_take;

    assign last_step = (step_reg == SW'(STEPS - 1));
    assign last_tmr  = (tmr_reg == TW'(NT - 1));
    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take && req_type == REQ_TICK)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (last_step && last_tmr)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.sel   = IDX_W'(tmr_reg);
        tmr_next  = tmr_reg;
        step_next = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                tmr_next  = '0;
                step_next = '0;
                if (req_take)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        cmd.tick_accept = 1'b1;
                    end
                    else
                    begin
                        cmd.apply_req = 1'b1;
                    end
                end
            end
            ST_STEP:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    cmd.timer_done = 1'b1;
                    step_next      = '0;
                    if (!last_tmr)
                    begin
                        tmr_next = tmr_reg + 1'b1;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tmr_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tmr_reg   <= tmr_next;
            step_reg  <= step_next;
        end
    end

endmodule

[hw/rtl/pbt_dpath.sv]
// Datapath: timer registers, tick counter, radix-4 remainder unit, result register.
module pbt_dpath
    import pbt_pkg::*;
#(
    parameter int NT         = 4,
    parameter int TICK_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [IDX_W-1:0]      timer_index,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  pbt_cmd_t              cmd,
    output pbt_sts_t              sts,
    output logic                  fire_valid,
    input  logic                  fire_stall,
    output logic [MASK_W-1:0]     fire_mask,
    output logic [OUT_TICK_W-1:0] tick_number
);

    localparam int TW       = (NT > 1) ? $clog2(NT) : 1;
    localparam int DIV_BITS = TICK_WIDTH + (TICK_WIDTH % 2);

    logic [PERIOD_W-1:0]   period_reg [NT];
    logic [NT-1:0]         running_reg;
    logic [MASK_W-1:0]     listener_reg;
    logic [TICK_WIDTH-1:0] tick_count_reg;
    logic [TICK_WIDTH-1:0] now_reg;
    logic [DIV_BITS-1:0]   div_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [NT-1:0]         fires_reg;
    logic                  out_valid_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic [OUT_TICK_W-1:0] out_tick_reg;

    logic [TW-1:0]         sel;
    logic [TW-1:0]         cfg_sel;
    logic [PERIOD_W-1:0]   p_sel;
    logic [PERIOD_W-1:0]   rem_s1;
    logic [PERIOD_W-1:0]   rem_s2;
    logic                  fire_bit;
    logic [MASK_W-1:0]     fires_ext;
    logic                  out_free;

    // one restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [PERIOD_W-1:0] rem_step(
        input logic [PERIOD_W-1:0] r,
        input logic                b,
        input logic [PERIOD_W-1:0] p
    );
        logic [PERIOD_W:0] t;
        t = {r, b};
        if (t >= {1'b0, p})
        begin
            t = t - {1'b0, p};
        end
        return t[PERIOD_W-1:0];
    endfunction

    assign sel     = cmd.sel[TW-1:0];
    assign cfg_sel = cfg_index[TW-1:0];
    assign p_sel   = period_reg[sel];
    assign rem_s1  = rem_step(rem_reg, div_reg[DIV_BITS-1], p_sel);
    assign rem_s2  = rem_step(rem_s1, div_reg[DIV_BITS-2], p_sel);

    assign fire_bit = (rem_s2 == '0) && running_reg[sel] && (p_sel != '0)
                      && listener_reg[cmd.sel];

    always_comb
    begin
        fires_ext = '0;
        for (int i = 0; i < NT; i++)
        begin
            fires_ext[i] = fires_reg[i];
        end
    end

    assign out_free     = !out_valid_reg || !fire_stall;
    assign sts.out_free = out_free;

    // control: run flags, registers, counter, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= '0;
            listener_reg   <= '0;
            tick_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NT; i++)
            begin
                period_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.apply_req)
            begin
                unique case (req_type)
                    REQ_START_ONE:
                    begin
                        if (int'(timer_index) < NT)
                        begin
                            running_reg[timer_index[TW-1:0]] <= 1'b1;
                        end
                    end
                    REQ_STOP_ONE:
                    begin
                        if (int'(timer_index) < NT)
                        begin
                            running_reg[timer_index[TW-1:0]] <= 1'b0;
                        end
                    end
                    REQ_START_ALL:
                    begin
                        running_reg <= '1;
                    end
                    REQ_STOP_ALL:
                    begin
                        running_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cfg_we)
            begin
                if (cfg_index <= REG_PERIOD_LAST && int'(cfg_index) < NT)
                begin
                    period_reg[cfg_sel]  <= cfg_data;
                    running_reg[cfg_sel] <= 1'b0;
                end
                else if (cfg_index == REG_LISTENER)
                begin
                    listener_reg <= cfg_data[MASK_W-1:0];
                end
            end
            if (cmd.tick_accept)
            begin
                tick_count_reg <= tick_count_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!fire_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.tick_accept)
        begin
            now_reg   <= tick_count_reg;
            div_reg   <= DIV_BITS'(tick_count_reg);
            rem_reg   <= '0;
            fires_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (cmd.timer_done)
            begin
                fires_reg[sel] <= fire_bit;
                div_reg        <= DIV_BITS'(now_reg);
                rem_reg        <= '0;
            end
            else
            begin
                div_reg <= {div_reg[DIV_BITS-3:0], 2'b00};
                rem_reg <= rem_s2;
            end
        end
        if (cmd.load_out)
        begin
            out_mask_reg <= fires_ext;
            out_tick_reg <= OUT_TICK_W'(now_reg);
        end
    end

    assign fire_valid  = out_valid_reg;
    assign fire_mask   = out_mask_reg;
    assign tick_number = out_tick_reg;

endmodule

[hw/rtl/periodic_timer_bank_unit.sv]
// Top level of the periodic timer bank: sequencer plus datapath.
//
// A bank of periodic timers sharing one tick counter. A tick beat tests every
// running, listened timer with a nonzero period against the current count and
// returns one result beat (fire_mask, tick_number); start/stop beats return
// nothing. Start/stop beats may follow one another every cycle while no tick
// is in progress. A tick beat covers NT = min(NUM_TIMERS, 4) timers and runs
// through the one shared remainder unit, which retires two dividend bits per
// cycle and walks the timers in turn. The result sits in an output register,
// so requests are taken while it waits; a following tick holds in its last
// cycle until that register frees. Configuration writes are always ready and
// must be issued while the bank is idle.
module periodic_timer_bank_unit
    import pbt_pkg::*;
#(
    parameter int NUM_TIMERS = 4,
    parameter int TICK_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [IDX_W-1:0]      timer_index,
    output logic                  fire_valid,
    input  logic                  fire_stall,
    output logic [MASK_W-1:0]     fire_mask,
    output logic [OUT_TICK_W-1:0] tick_number,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // timers past the period registers can never fire
    localparam int NT    = (NUM_TIMERS < MAX_TIMERS) ? NUM_TIMERS : MAX_TIMERS;
    localparam int STEPS = (TICK_WIDTH + 1) / 2;

    pbt_cmd_t cmd;
    pbt_sts_t sts;

    assign cfg_ready = 1'b1;

    pbt_ctrl #(
        .NT    (NT),
        .STEPS (STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    pbt_dpath #(
        .NT         (NT),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .timer_index (timer_index),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .fire_valid  (fire_valid),
        .fire_stall  (fire_stall),
        .fire_mask   (fire_mask),
        .tick_number (tick_number)
    );

endmodule

[test/testbench.sv]
// Self-checking testbench for the periodic timer bank: directed cases, then random traffic.
module testbench;
    import pbt_pkg::*;

    localparam int NUM_TIMERS    = 4;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 80;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 100;

    // request codes the bank ignores, and the bounds of the register index
    localparam logic [REQ_W-1:0]     REQ_RESERVED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0]     REQ_RESERVED_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP      = 3'd7;

    typedef struct packed {
        logic [MASK_W-1:0]     mask;
        logic [OUT_TICK_W-1:0] count;
    } fire_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [REQ_W-1:0]      req_type = REQ_TICK;
    logic [IDX_W-1:0]      timer_index = '0;
    logic                  fire_valid;
    logic                  fire_stall = 1'b0;
    logic [MASK_W-1:0]     fire_mask;
    logic [OUT_TICK_W-1:0] tick_number;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the bank
    logic [OUT_TICK_W-1:0] shadow_tick;
    logic [NUM_TIMERS-1:0] shadow_running;
    logic [PERIOD_W-1:0]   shadow_period [NUM_TIMERS];
    logic [MASK_W-1:0]     shadow_listen;

    fire_t pending_fires[$];
    fire_t head;

    int errors = 0;
    int beats_sent = 0;
    int ticks_sent = 0;
    int ignored_sent = 0;
    int fires_checked = 0;
    int reg_writes = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit stall_en = 1'b1;
    bit idle_en = 1'b1;

    periodic_timer_bank_unit #(
        .NUM_TIMERS(NUM_TIMERS),
        .TICK_WIDTH(OUT_TICK_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .timer_index(timer_index),
        .fire_valid(fire_valid),
        .fire_stall(fire_stall),
        .fire_mask(fire_mask),
        .tick_number(tick_number),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return PERIOD_W'($urandom_range(1, 8));
        if (r < 70) return PERIOD_W'($urandom_range(9, 64));
        if (r < 80) return '0;
        if (r < 90) return '1;
        return PERIOD_W'($urandom);
    endfunction

    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        if (idx <= REG_PERIOD_LAST) begin
            if (idx < NUM_TIMERS) begin
                shadow_period[idx[IDX_W-1:0]] = val[PERIOD_W-1:0];
                shadow_running[idx[IDX_W-1:0]] = 1'b0;
            end
        end else if (idx == REG_LISTENER) begin
            shadow_listen = val[MASK_W-1:0];
        end
    endtask

    task automatic advance_bank(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx);
        fire_t fired;
        case (kind)
            REQ_TICK: begin
                fired.mask = '0;
                fired.count = shadow_tick;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (shadow_running[i] && shadow_period[i] != 0 && shadow_listen[i]
                            && (shadow_tick % {16'b0, shadow_period[i]}) == 0)
                        fired.mask[i] = 1'b1;
                end
                pending_fires.push_back(fired);
                shadow_tick = shadow_tick + 1'b1;
            end
            REQ_START_ONE: if (idx < NUM_TIMERS) shadow_running[idx] = 1'b1;
            REQ_STOP_ONE:  if (idx < NUM_TIMERS) shadow_running[idx] = 1'b0;
            REQ_START_ALL: shadow_running = '1;
            REQ_STOP_ALL:  shadow_running = '0;
            default: ;
        endcase
    endtask

    // leaves cfg_valid high; cfg_release drops it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_cfg(idx, val);
        reg_writes++;
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // one request beat; valid stays high so back-to-back beats need no re-raise
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 1) == 1)
            gap = gap_len();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= kind;
        timer_index <= idx;
        do @(posedge clk); while (req_stall);
        advance_bank(kind, idx);
        if (kind == REQ_TICK)
            ticks_sent++;
        if (kind >= REQ_RESERVED_FIRST)
            ignored_sent++;
        else
            beats_sent++;
    endtask

    // hold off the sender until every fire result is back and the bank is quiet
    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_fires.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_fire_pattern();
        cfg_write(REG_PERIOD_FIRST, 16'd1);
        cfg_write(REG_PERIOD_FIRST + 3'd1, 16'd2);
        cfg_write(REG_PERIOD_FIRST + 3'd2, 16'hFFFF);
        cfg_write(REG_PERIOD_LAST, 16'd3);
        cfg_write(REG_LISTENER, 16'hFFFF);
        cfg_release();
        send_req(REQ_START_ALL, 2'd0);
        repeat (4) send_req(REQ_TICK, 2'd3);
        for (int c = REQ_RESERVED_FIRST; c <= REQ_RESERVED_LAST; c++)
            send_req(REQ_W'(c), 2'd2);
        send_req(REQ_STOP_ONE, 2'd0);
        send_req(REQ_TICK, 2'd0);
        send_req(REQ_START_ONE, 2'd0);
        send_req(REQ_STOP_ONE, 2'd1);
        send_req(REQ_TICK, 2'd1);
        send_req(REQ_STOP_ALL, 2'd3);
        send_req(REQ_TICK, 2'd0);
    endtask

    // zero period: running flag set but never fires; period write stops the timer
    task automatic test_zero_period();
        settle();
        cfg_write(REG_PERIOD_LAST, 16'd0);
        cfg_write(REG_PERIOD_FIRST + 3'd1, 16'd0);
        cfg_release();
        send_req(REQ_START_ONE, 2'd3);
        send_req(REQ_START_ONE, 2'd1);
        send_req(REQ_TICK, 2'd0);
        send_req(REQ_START_ALL, 2'd0);
        send_req(REQ_TICK, 2'd0);
        settle();
        cfg_write(REG_PERIOD_LAST, 16'd4);
        cfg_release();
        send_req(REQ_TICK, 2'd0);
        send_req(REQ_START_ONE, 2'd3);
        repeat (3) send_req(REQ_TICK, 2'd0);
    endtask

    // listener mask gates reports; writes past the last register do nothing
    task automatic test_listener_mask();
        settle();
        cfg_write(REG_LISTENER, 16'h0000);
        for (int r = REG_LISTENER + 1; r <= REG_INDEX_TOP; r++)
            cfg_write(CFG_IDX_W'(r), 16'hFFFF);
        cfg_release();
        send_req(REQ_START_ALL, 2'd0);
        repeat (2) send_req(REQ_TICK, 2'd0);
        settle();
        cfg_write(REG_LISTENER, 16'h000A);
        cfg_release();
        send_req(REQ_START_ALL, 2'd0);
        repeat (4) send_req(REQ_TICK, 2'd0);
    endtask

    task automatic test_random_traffic();
        int r;
        int done;
        logic [REQ_W-1:0] kind;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            idle_en  = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
            for (int t = 0; t < NUM_TIMERS; t++)
                if (ph == 0 || $urandom_range(0, 9) < 7)
                    cfg_write(REG_PERIOD_FIRST + CFG_IDX_W'(t), pick_period());
            if (ph == 0 || $urandom_range(0, 9) < 7)
                cfg_write(REG_LISTENER, $urandom_range(0, 2) == 0 ? 16'hFFFF
                                                                  : CFG_DATA_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(REG_LISTENER + 1, REG_INDEX_TOP)),
                          CFG_DATA_W'($urandom));
            cfg_release();
            done = 0;
            while (done < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 55)      kind = REQ_TICK;
                else if (r < 70) kind = REQ_START_ONE;
                else if (r < 82) kind = REQ_STOP_ONE;
                else if (r < 88) kind = REQ_START_ALL;
                else if (r < 94) kind = REQ_STOP_ALL;
                else kind = REQ_W'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
                send_req(kind, IDX_W'($urandom));
                if (kind < REQ_RESERVED_FIRST)
                    done++;
            end
        end
        idle_en  = 1'b1;
        stall_en = 1'b1;
    endtask

    // receiver back-pressure
    always @(posedge clk) begin
        if (stall_left == 0 && stall_en && $urandom_range(0, 3) == 0)
            stall_left = gap_len();
        if (stall_left > 0) begin
            stall_left--;
            fire_stall <= 1'b1;
        end else begin
            fire_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && fire_valid && !fire_stall) begin
            if (pending_fires.size() == 0) begin
                $error("unexpected fire beat: fire_mask=%h tick_number=%0d", fire_mask, tick_number);
                errors++;
            end else begin
                head = pending_fires.pop_front();
                if (fire_mask !== head.mask) begin
                    $error("fire_mask: expected %h, got %h", head.mask, fire_mask);
                    errors++;
                end
                if (tick_number !== head.count) begin
                    $error("tick_number: expected %0d, got %0d", head.count, tick_number);
                    errors++;
                end
                fires_checked++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (fire_valid && !fire_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_fires.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        shadow_tick = '0;
        shadow_running = '0;
        shadow_listen = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
            shadow_period[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_fire_pattern();
        test_zero_period();
        test_listener_mask();
        test_random_traffic();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_fires.size() != 0) begin
            $error("%0d fire results never arrived", pending_fires.size());
            errors++;
        end
        $display("Sent %0d request beats (%0d ticks) plus %0d reserved codes, %0d register writes",
                 beats_sent, ticks_sent, ignored_sent, reg_writes);
        $display("Checked %0d fire results over %0d random phases, %0d mismatches",
                 fires_checked, PHASES, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pbt_pkg.sv
hw/rtl/pbt_ctrl.sv
hw/rtl/pbt_dpath.sv
hw/rtl/periodic_timer_bank_unit.sv
test/testbench.sv
